/* hdl/ksdq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksdq_pkg
// Shared types and codes of the keyed sorted delay queue.
// ----------------------------------------------------------------------------
package ksdq_pkg;

  localparam int unsigned StationW = 17;
  localparam int unsigned TimeW    = 32;

  // Most entries reported by one expire item
  localparam int unsigned MAX_RESULTS = 32;

  typedef struct packed {
    logic [StationW-1:0] station;
    logic [TimeW-1:0]    obs_time;
    logic [TimeW-1:0]    rel_time;
  } entry_t;

  // Operation codes on the input tuser
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_TAKE   = 2'd1;
  localparam logic [1:0] FUNC_EXPIRE = 2'd2;

  // Result status codes on the output tuser
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_KEPT     = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TAKEN    = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_EXPIRED  = 3'd6;
  localparam logic [2:0] ST_NONE_DUE = 3'd7;

endpackage

/* hdl/ksdq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksdq_ram
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ksdq_ram #(
  parameter int DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  ksdq_pkg::entry_t           wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output ksdq_pkg::entry_t           rdata_o
);
  import ksdq_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/keyed_sorted_delay_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_sorted_delay_queue
// Queue of keyed entries kept in release-time order in a single RAM.
//
//   channel  dir  tdata (low bit up)                         tuser   tlast
//   s_axis   in   station, obs_time, release_time,           func    -
//                 replace, now_time
//   m_axis   out  out_station, out_obs_time,                 status  last
//                 out_release_time
//
// One item at a time. Add and take scan every stored entry; where an entry is
// added, moved or taken, they then shift the entries behind the changed place
// one per cycle, and each gives one result. Expire gives one due entry a cycle
// while the output is not stalled, then closes the gap, or gives one none-due
// result. The single RAM read port steps one entry per cycle. Reset empties
// the queue at once; a stalled output holds the sequencer in the expire or result state.
// ----------------------------------------------------------------------------
module keyed_sorted_delay_queue #(
  parameter int DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // station[16:0], obs_time[48:17], release_time[80:49], replace[81],
  // now_time[113:82], zero fill
  input  logic [119:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_station[16:0], out_obs_time[48:17], out_release_time[80:49], zero fill
  output logic [87:0]  m_axis_tdata,
  // status[2:0]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import ksdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EXP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  // control
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          found_q, found_d;
  logic          pset_q, pset_d;
  logic          pend_q, pend_d;
  logic          hold_v_q, hold_v_d;
  logic          m_valid_q, m_valid_d;

  // payload
  logic [1:0]          func_q, func_d;
  logic [StationW-1:0] st_q, st_d;
  logic [TimeW-1:0]    obs_q, obs_d;
  logic [TimeW-1:0]    rel_q, rel_d;
  logic                repl_q, repl_d;
  logic [TimeW-1:0]    now_q, now_d;
  logic [CW-1:0]       m_q, m_d;
  logic [CW-1:0]       p_q, p_d;
  entry_t              hit_q, hit_d;
  entry_t              hold_q, hold_d;
  logic [2:0]          res_status_q, res_status_d;
  entry_t              res_q, res_d;
  logic                sh_up_q, sh_up_d;
  logic [AW-1:0]       sh_src_q, sh_src_d;
  logic [AW-1:0]       sh_dst_q, sh_dst_d;
  logic [CW-1:0]       sh_n_q, sh_n_d;
  logic [AW-1:0]       pend_dst_q, pend_dst_d;
  logic                fin_q, fin_d;
  logic [AW-1:0]       fin_addr_q, fin_addr_d;
  logic [2:0]          m_status_q, m_status_d;
  entry_t              m_entry_q, m_entry_d;
  logic                m_last_q, m_last_d;

  // RAM port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  entry_t        new_entry;
  logic          slot_free;
  logic          due;

  assign new_entry = '{station: st_q, obs_time: obs_q, rel_time: rel_q};
  assign slot_free = !m_valid_q || m_axis_tready;
  assign due = (idx_q < count_q) && (32'(idx_q) < MAX_RESULTS) &&
               (mem_rdata.rel_time <= now_q);

  ksdq_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Read address
  always_comb begin
    unique case (state_q)
      S_SCAN:  mem_raddr = AW'(idx_q + 1'b1);
      S_EXP:   mem_raddr = (slot_free && due) ? AW'(idx_q + 1'b1) : AW'(idx_q);
      S_SHIFT: mem_raddr = sh_src_q;
      default: mem_raddr = '0;
    endcase
  end

  // Write port: moved entries while shifting, then the new entry
  assign mem_we    = (state_q == S_SHIFT) && (pend_q || (sh_n_q == '0 && fin_q));
  assign mem_waddr = pend_q ? pend_dst_q : fin_addr_q;
  assign mem_wdata = pend_q ? mem_rdata : new_entry;

  always_comb begin
    logic [CW-1:0] p_adj;

    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    found_d      = found_q;
    pset_d       = pset_q;
    pend_d       = 1'b0;
    hold_v_d     = hold_v_q;
    func_d       = func_q;
    st_d         = st_q;
    obs_d        = obs_q;
    rel_d        = rel_q;
    repl_d       = repl_q;
    now_d        = now_q;
    m_d          = m_q;
    p_d          = p_q;
    hit_d        = hit_q;
    hold_d       = hold_q;
    res_status_d = res_status_q;
    res_d        = res_q;
    sh_up_d      = sh_up_q;
    sh_src_d     = sh_src_q;
    sh_dst_d     = sh_dst_q;
    sh_n_d       = sh_n_q;
    pend_dst_d   = pend_dst_q;
    fin_d        = fin_q;
    fin_addr_d   = fin_addr_q;
    m_status_d   = m_status_q;
    m_entry_d    = m_entry_q;
    m_last_d     = m_last_q;
    m_valid_d    = m_valid_q && !m_axis_tready;

    // insert place once the old entry is gone
    p_adj = (p_q > m_q) ? CW'(p_q - 1'b1) : p_q;

    unique case (state_q)
      S_IDLE: begin
        func_d   = s_axis_tuser;
        st_d     = s_axis_tdata[16:0];
        obs_d    = s_axis_tdata[48:17];
        rel_d    = s_axis_tdata[80:49];
        repl_d   = s_axis_tdata[81];
        now_d    = s_axis_tdata[113:82];
        idx_d    = '0;
        found_d  = 1'b0;
        pset_d   = 1'b0;
        p_d      = count_q;
        hold_v_d = 1'b0;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == FUNC_ADD || s_axis_tuser == FUNC_TAKE) begin
            state_d = S_SCAN;
          end else if (s_axis_tuser == FUNC_EXPIRE) begin
            state_d = S_EXP;
          end
        end
      end

      S_SCAN: begin
        if (idx_q < count_q) begin
          idx_d = CW'(idx_q + 1'b1);
          if (mem_rdata.station == st_q && mem_rdata.obs_time == obs_q) begin
            found_d = 1'b1;
            m_d     = idx_q;
            hit_d   = mem_rdata;
          end else if (!pset_q && mem_rdata.rel_time >= rel_q) begin
            pset_d = 1'b1;
            p_d    = idx_q;
          end
        end else begin
          state_d = S_RESP;
          fin_d   = 1'b0;
          sh_n_d  = '0;
          if (func_q == FUNC_ADD) begin
            if (found_q) begin
              if (repl_q && hit_q.rel_time != rel_q) begin
                // move the entry to its new place
                res_status_d = ST_REPLACED;
                res_d        = new_entry;
                state_d      = S_SHIFT;
                fin_d        = 1'b1;
                fin_addr_d   = AW'(p_adj);
                sh_dst_d     = AW'(m_q);
                if (p_adj <= m_q) begin
                  sh_up_d  = 1'b1;
                  sh_src_d = AW'(m_q - 1'b1);
                  sh_n_d   = CW'(m_q - p_adj);
                end else begin
                  sh_up_d  = 1'b0;
                  sh_src_d = AW'(m_q + 1'b1);
                  sh_n_d   = CW'(p_adj - m_q);
                end
              end else begin
                res_status_d = ST_KEPT;
                res_d        = hit_q;
              end
            end else if (count_q == CW'(DEPTH)) begin
              res_status_d = ST_FULL;
              res_d        = new_entry;
            end else begin
              res_status_d = ST_ADDED;
              res_d        = new_entry;
              state_d      = S_SHIFT;
              count_d      = CW'(count_q + 1'b1);
              fin_d        = 1'b1;
              fin_addr_d   = AW'(p_q);
              sh_up_d      = 1'b1;
              sh_dst_d     = AW'(count_q);
              sh_src_d     = AW'(count_q - 1'b1);
              sh_n_d       = CW'(count_q - p_q);
            end
          end else begin
            if (found_q) begin
              res_status_d = ST_TAKEN;
              res_d        = hit_q;
              state_d      = S_SHIFT;
              count_d      = CW'(count_q - 1'b1);
              sh_up_d      = 1'b0;
              sh_dst_d     = AW'(m_q);
              sh_src_d     = AW'(m_q + 1'b1);
              sh_n_d       = CW'(count_q - m_q - 1'b1);
            end else begin
              res_status_d = ST_NOTFOUND;
              res_d        = '{station: st_q, obs_time: obs_q, rel_time: '0};
            end
          end
        end
      end

      S_EXP: begin
        if (slot_free) begin
          if (hold_v_q) begin
            m_valid_d  = 1'b1;
            m_status_d = ST_EXPIRED;
            m_entry_d  = hold_q;
            m_last_d   = !due;
          end
          if (due) begin
            hold_d   = mem_rdata;
            hold_v_d = 1'b1;
            idx_d    = CW'(idx_q + 1'b1);
          end else begin
            hold_v_d = 1'b0;
            if (idx_q == '0) begin
              m_valid_d  = 1'b1;
              m_status_d = ST_NONE_DUE;
              m_entry_d  = '0;
              m_last_d   = 1'b1;
              state_d    = S_IDLE;
            end else begin
              // drop the reported head entries
              state_d  = S_SHIFT;
              count_d  = CW'(count_q - idx_q);
              fin_d    = 1'b0;
              sh_up_d  = 1'b0;
              sh_dst_d = '0;
              sh_src_d = AW'(idx_q);
              sh_n_d   = CW'(count_q - idx_q);
            end
          end
        end
      end

      S_SHIFT: begin
        if (sh_n_q != '0) begin
          pend_d     = 1'b1;
          pend_dst_d = sh_dst_q;
          sh_src_d   = sh_up_q ? AW'(sh_src_q - 1'b1) : AW'(sh_src_q + 1'b1);
          sh_dst_d   = sh_up_q ? AW'(sh_dst_q - 1'b1) : AW'(sh_dst_q + 1'b1);
          sh_n_d     = CW'(sh_n_q - 1'b1);
        end else if (!pend_q) begin
          state_d = (func_q == FUNC_EXPIRE) ? S_IDLE : S_RESP;
        end
      end

      S_RESP: begin
        if (slot_free) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_entry_d  = res_q;
          m_last_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      found_q   <= 1'b0;
      pset_q    <= 1'b0;
      pend_q    <= 1'b0;
      hold_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      found_q   <= found_d;
      pset_q    <= pset_d;
      pend_q    <= pend_d;
      hold_v_q  <= hold_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    st_q         <= st_d;
    obs_q        <= obs_d;
    rel_q        <= rel_d;
    repl_q       <= repl_d;
    now_q        <= now_d;
    m_q          <= m_d;
    p_q          <= p_d;
    hit_q        <= hit_d;
    hold_q       <= hold_d;
    res_status_q <= res_status_d;
    res_q        <= res_d;
    sh_up_q      <= sh_up_d;
    sh_src_q     <= sh_src_d;
    sh_dst_q     <= sh_dst_d;
    sh_n_q       <= sh_n_d;
    pend_dst_q   <= pend_dst_d;
    fin_q        <= fin_d;
    fin_addr_q   <= fin_addr_d;
    m_status_q   <= m_status_d;
    m_entry_q    <= m_entry_d;
    m_last_q     <= m_last_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {7'd0, m_entry_q.rel_time, m_entry_q.obs_time,
                          m_entry_q.station};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && pend_q && sh_n_q != '0) |-> mem_raddr != pend_dst_q)
    else $error("shift reads the entry it writes");

  a_exp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXP) |-> (32'(idx_q) <= MAX_RESULTS && idx_q <= count_q))
    else $error("expire index out of range");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == FUNC_ADD || s_axis_tuser == FUNC_TAKE ||
      s_axis_tuser == FUNC_EXPIRE)) |=> state_q != S_IDLE)
    else $error("valid item accepted but sequencer stayed idle");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyed_sorted_delay_queue.
//
// Adds, takes and expires go in through the input stream and are mirrored in
// a software copy of the sorted queue, which queues the results each item
// should give. Every result leaving the block is checked field by field
// against the oldest queued one. A short directed run covers the corner cases;
// a random run follows, with bursts that fill the queue to overflow and then
// expire its due entries. Sender gaps and receiver stalls vary over the run.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [2:0]       status;
  ksdq_pkg::entry_t ent;
  logic             last;
} report_t;

class queue_tracker #(int Depth = 32);
  ksdq_pkg::entry_t slots[Depth];
  int unsigned      fill;
  report_t          due_reports[$];
  int unsigned      mismatches;

  function new();
    fill       = 0;
    mismatches = 0;
  endfunction

  function void push_report(logic [2:0] status, ksdq_pkg::entry_t e, logic last);
    report_t r;
    r.status = status;
    r.ent    = e;
    r.last   = last;
    due_reports = {due_reports, r};
  endfunction

  function int find_key(logic [16:0] station, logic [31:0] obs_time);
    for (int i = 0; i < fill; i++) begin
      if (slots[i].station == station && slots[i].obs_time == obs_time) return i;
    end
    return -1;
  endfunction

  function void drop_at(int pos);
    for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
    fill--;
  endfunction

  // New entry goes before the first one whose release time is equal or later
  function void place_sorted(ksdq_pkg::entry_t e);
    int pos;
    pos = 0;
    while (pos < fill && slots[pos].rel_time < e.rel_time) pos++;
    for (int i = fill; i > pos; i--) slots[i] = slots[i - 1];
    slots[pos] = e;
    fill++;
  endfunction

  function void apply_request(logic [1:0] func, ksdq_pkg::entry_t e, logic repl,
                              logic [31:0] now_time);
    int               idx;
    int               n;
    ksdq_pkg::entry_t blank;
    blank = '0;
    idx   = find_key(e.station, e.obs_time);
    case (func)
      ksdq_pkg::FUNC_ADD: begin
        if (idx >= 0) begin
          if (repl && slots[idx].rel_time != e.rel_time) begin
            drop_at(idx);
            place_sorted(e);
            push_report(ksdq_pkg::ST_REPLACED, e, 1'b1);
          end else begin
            push_report(ksdq_pkg::ST_KEPT, slots[idx], 1'b1);
          end
        end else if (fill >= Depth) begin
          push_report(ksdq_pkg::ST_FULL, e, 1'b1);
        end else begin
          place_sorted(e);
          push_report(ksdq_pkg::ST_ADDED, e, 1'b1);
        end
      end
      ksdq_pkg::FUNC_TAKE: begin
        if (idx < 0) begin
          blank.station  = e.station;
          blank.obs_time = e.obs_time;
          push_report(ksdq_pkg::ST_NOTFOUND, blank, 1'b1);
        end else begin
          push_report(ksdq_pkg::ST_TAKEN, slots[idx], 1'b1);
          drop_at(idx);
        end
      end
      ksdq_pkg::FUNC_EXPIRE: begin
        n = 0;
        while (n < fill && n < ksdq_pkg::MAX_RESULTS && slots[n].rel_time <= now_time) n++;
        if (n == 0) begin
          push_report(ksdq_pkg::ST_NONE_DUE, blank, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            push_report(ksdq_pkg::ST_EXPIRED, slots[i], i == n - 1);
          for (int i = 0; i + n < fill; i++) slots[i] = slots[i + n];
          fill -= n;
        end
      end
      default: ;  // unused code: no result
    endcase
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_reply(logic [2:0] status, ksdq_pkg::entry_t got, logic last);
    report_t want;
    if (due_reports.size() == 0) begin
      $error("result with none outstanding: status %0d station %0d", status, got.station);
      mismatches++;
      return;
    end
    want = due_reports.pop_front();
    compare_field("status", 32'(want.status), 32'(status));
    compare_field("out_station", 32'(want.ent.station), 32'(got.station));
    compare_field("out_obs_time", want.ent.obs_time, got.obs_time);
    compare_field("out_release_time", want.ent.rel_time, got.rel_time);
    compare_field("last", 32'(want.last), 32'(last));
  endfunction
endclass

module testbench;
  import ksdq_pkg::*;

  localparam int          QueueDepth  = 32;
  localparam int          RandomItems = 190;
  localparam logic [1:0]  FuncUnused  = 2'd3;

  typedef enum logic [1:0] {RxSteady, RxRandom, RxBursty} rx_mode_e;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = FUNC_ADD;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  queue_tracker #(QueueDepth) tracker;
  int                         burst_left = 0;
  rx_mode_e                   rx_mode    = RxSteady;
  int                         rx_left    = 0;
  logic [2:0]                 rx_phase   = '0;

  keyed_sorted_delay_queue #(
    .DEPTH(QueueDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: switches between always ready, random stalls and a fixed stall rhythm
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 3'd1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxSteady: m_axis_tready <= 1'b1;
      RxRandom: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:  m_axis_tready <= (rx_phase < 3'd3);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_reply(m_axis_tuser, entry_t'{m_axis_tdata[16:0], m_axis_tdata[48:17],
                          m_axis_tdata[80:49]}, m_axis_tlast);
  end

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // Called just after a rising edge; returns just after the accepting edge
  task automatic send_request(logic [1:0] func, logic [16:0] station, logic [31:0] obs_time,
                              logic [31:0] rel_time, logic repl, logic [31:0] now_time);
    entry_t e;
    e = '{station, obs_time, rel_time};
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'd0, now_time, repl, rel_time, obs_time, station};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    tracker.apply_request(func, e, repl, now_time);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.due_reports.size() != 0);
  endtask

  initial begin
    int          counted;
    int          idx;
    int          pick;
    logic [1:0]  func;
    logic [16:0] station;
    logic [31:0] obs_time;

    tracker = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases
    send_request(FUNC_EXPIRE, 17'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);   // empty, nothing due
    send_request(FUNC_TAKE, 17'd5, 32'd100, 32'd0, 1'b0, 32'd0);           // empty, not found
    send_request(FUNC_ADD, 17'd0, 32'd0, 32'd0, 1'b0, 32'd0);
    send_request(FUNC_ADD, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_request(FUNC_ADD, 17'd99999, 32'd1000, 32'd500, 1'b0, 32'd0);
    send_request(FUNC_ADD, 17'd12, 32'd1000, 32'd500, 1'b0, 32'd0);       // ties go in front
    send_request(FUNC_ADD, 17'd99999, 32'd1000, 32'd700, 1'b0, 32'd0);    // match, kept
    send_request(FUNC_ADD, 17'd99999, 32'd1000, 32'd500, 1'b1, 32'd0);    // same time, kept
    send_request(FUNC_ADD, 17'd99999, 32'd1000, 32'd20, 1'b1, 32'd0);     // replaced, moves up
    send_request(FUNC_ADD, 17'd0, 32'd0, 32'd600, 1'b1, 32'd0);           // replaced, moves down
    send_request(FUNC_TAKE, 17'd12, 32'd1000, 32'd0, 1'b0, 32'd0);
    send_request(FUNC_TAKE, 17'd12, 32'd1000, 32'd0, 1'b0, 32'd0);
    send_request(FuncUnused, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_request(FUNC_EXPIRE, 17'd0, 32'd0, 32'd0, 1'b0, 32'd0);
    send_request(FUNC_EXPIRE, 17'd0, 32'd0, 32'd0, 1'b0, 32'd600);
    send_request(FUNC_TAKE, 17'h1FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0);
    send_request(FUNC_EXPIRE, 17'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    send_request(FUNC_ADD, 17'd7, 32'd7, 32'd7, 1'b1, 32'hFFFF_FFFF);
    send_request(FUNC_EXPIRE, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd7);
    wait_drained();

    counted = 0;
    while (counted < RandomItems) begin
      if (counted % 70 == 0) begin
        // Overflow the queue, then release its due entries in one expire
        repeat (QueueDepth + 2 - tracker.fill) begin
          send_request(FUNC_ADD, 17'($urandom_range(0, 131071)), $urandom(), pick_time(),
                       1'($urandom()), $urandom());
          counted++;
        end
        send_request(FUNC_EXPIRE, 17'($urandom()), $urandom(), $urandom(), 1'($urandom()),
                     ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : pick_time());
        counted++;
      end
      if (counted % 50 == 25) wait_drained();

      pick = $urandom_range(0, 99);
      if (pick < 45)      func = FUNC_ADD;
      else if (pick < 72) func = FUNC_TAKE;
      else if (pick < 95) func = FUNC_EXPIRE;
      else                func = FuncUnused;

      station  = 17'($urandom_range(0, 131071));
      obs_time = pick_time();
      if (tracker.fill > 0 && $urandom_range(0, 9) < 6) begin
        idx      = $urandom_range(0, tracker.fill - 1);
        station  = tracker.slots[idx].station;
        obs_time = tracker.slots[idx].obs_time;
      end
      send_request(func, station, obs_time, pick_time(), 1'($urandom()), pick_time());
      if (func != FuncUnused) counted++;
    end

    wait_drained();
    // A stray result would show up in this window
    repeat (200) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.due_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ksdq_pkg.sv
hdl/ksdq_ram.sv
hdl/keyed_sorted_delay_queue.sv
sim/testbench.sv
